// ===== sv/binary_weight_int8_block_dot_defines.svh =====
// assertion macros for the port-level checker file
`ifndef BINARY_WEIGHT_INT8_BLOCK_DOT_DEFINES_SVH
`define BINARY_WEIGHT_INT8_BLOCK_DOT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BWD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define BWD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/bwd_pkg.sv =====
// shared types, constants and float unpack helpers for the block dot unit
package bwd_pkg;

   localparam int CHUNK_GROUPS         = 4;
   localparam int GROUP_LANES          = 8;
   localparam int CHUNKS_PER_BLOCK_DEF = 4;
   localparam int REQ_DATA_W           = 320;
   localparam logic [31:0] FP32_QNAN     = 32'h7fc0_0000;
   localparam logic [31:0] FP32_EXP_MASK = 32'h7f80_0000;

   typedef enum logic [1:0] {CLS_ZERO, CLS_FIN, CLS_INF, CLS_NAN} bwd_cls_type;
   typedef enum logic {OP_MUL, OP_ADD} bwd_op_type;

   // value = man * 2^(ex - 150) for finite operands
   typedef struct packed {
      bwd_cls_type cls;
      logic        sgn;
      logic [8:0]  ex;
      logic [23:0] man;
   } bwd_opnd_type;

   typedef struct packed {
      logic         start;
      bwd_op_type   op;
      bwd_opnd_type a;
      bwd_opnd_type b;
   } bwd_fpu_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } bwd_fpu_rsp_type;

   function automatic bwd_opnd_type unpack_fp32(logic [31:0] b);
      bwd_opnd_type o;
      o.sgn = b[31];
      o.ex  = 9'd1;
      o.man = {1'b0, b[22:0]};
      if (b[30:23] == 8'hff) begin
         o.cls = (b[22:0] != 23'd0) ? CLS_NAN : CLS_INF;
      end else if (b[30:23] == 8'h00) begin
         o.cls = (b[22:0] != 23'd0) ? CLS_FIN : CLS_ZERO;
      end else begin
         o.cls = CLS_FIN;
         o.ex  = {1'b0, b[30:23]};
         o.man = {1'b1, b[22:0]};
      end
      return o;
   endfunction

   // fp16 is taken exactly; exponent rebased onto the fp32 scale
   function automatic bwd_opnd_type unpack_fp16(logic [15:0] h);
      bwd_opnd_type o;
      o.sgn = h[15];
      o.ex  = 9'd126;
      o.man = {14'd0, h[9:0]};
      if (h[14:10] == 5'h1f) begin
         o.cls = (h[9:0] != 10'd0) ? CLS_NAN : CLS_INF;
      end else if (h[14:10] == 5'h00) begin
         o.cls = (h[9:0] != 10'd0) ? CLS_FIN : CLS_ZERO;
      end else begin
         o.cls = CLS_FIN;
         o.ex  = 9'(h[14:10]) + 9'd125;
         o.man = {13'd0, 1'b1, h[9:0]};
      end
      return o;
   endfunction

   // exact integer chunk sum as an operand
   function automatic bwd_opnd_type from_int(logic signed [13:0] s);
      bwd_opnd_type o;
      logic [13:0]  mag;
      mag   = s[13] ? 14'(-s) : 14'(s);
      o.sgn = s[13];
      o.ex  = 9'd150;
      o.man = {10'd0, mag};
      o.cls = (s == 14'sd0) ? CLS_ZERO : CLS_FIN;
      return o;
   endfunction

endpackage

// ===== sv/binary_weight_int8_block_dot.sv =====
// Binary-weight by int8 block dot product: one 32-element chunk per transfer.
// The block is busy from the accepted chunk until its work is done: it first
// forms the exact integer chunk sum (eight lanes a cycle), then two fp32
// operations, four when a block closes, run one after another on the single
// shared multiply/add unit. An operation whose result is zero, infinite or nan
// is settled at its start; any other passes through start, normalize check,
// subnormal check, rounding and result handoff, with normalize or subnormal
// shift steps of eight or one bit, so the shared float unit mostly sets how
// long a chunk holds the input.
// A chunk with tlast waits in its final step only if the previous result has
// not yet been taken; a chunk is accepted while a result is still waiting.
module binary_weight_int8_block_dot #(
   parameter int CHUNKS_PER_BLOCK = bwd_pkg::CHUNKS_PER_BLOCK_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // act_bytes_0, act_bytes_1, act_bytes_2, act_bytes_3, weight_bits,
   // act_scale, weight_scale
   input  logic [bwd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // dot_value
   output logic [31:0]                   rsp_tdata,
   // partial_block
   output logic                          rsp_tuser
);

   localparam int PosW = (CHUNKS_PER_BLOCK > 1) ? $clog2(CHUNKS_PER_BLOCK) : 1;
   localparam int CntW = $clog2(bwd_pkg::CHUNK_GROUPS);

   typedef enum logic [3:0] {
      S_IDLE, S_SUM, S_P_GO, S_P_WAIT, S_B_GO, S_B_WAIT,
      S_Q_GO, S_Q_WAIT, S_T_GO, S_T_WAIT, S_FIN
   } state_type;

   state_type          state_ff, state_in;
   logic [63:0]        act_ff [bwd_pkg::CHUNK_GROUPS];
   logic [63:0]        act_in [bwd_pkg::CHUNK_GROUPS];
   logic [7:0]         wb_ff  [bwd_pkg::CHUNK_GROUPS];
   logic [7:0]         wb_in  [bwd_pkg::CHUNK_GROUPS];
   logic [15:0]        ascale_ff, ascale_in;
   logic [15:0]        hws_ff, hws_in;
   logic               last_ff, last_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic [PosW-1:0]    pos_ff, pos_in;
   logic signed [13:0] sum_ff, sum_in;
   logic [31:0]        block_ff, block_in;
   logic [31:0]        total_ff, total_in;
   logic [31:0]        tmp_ff, tmp_in;
   logic               ovalid_ff, ovalid_in;
   logic [31:0]        odata_ff, odata_in;
   logic               ouser_ff, ouser_in;

   bwd_pkg::bwd_fpu_req_type fpu_req;
   bwd_pkg::bwd_fpu_rsp_type fpu_rsp;

   logic               accept, full, out_free;
   logic signed [11:0] lane_acc;
   logic signed [8:0]  lane_val;

   assign accept   = req_tvalid && req_tready;
   assign full     = (pos_ff == PosW'(CHUNKS_PER_BLOCK - 1));
   assign out_free = !ovalid_ff || rsp_tready;

   // signed sum of eight lanes of the current group
   always_comb begin
      lane_acc = 12'sd0;
      lane_val = 9'sd0;
      for (int i = 0; i < bwd_pkg::GROUP_LANES; i++) begin
         lane_val = 9'(signed'(act_ff[cnt_ff][8*i +: 8]));
         lane_acc = wb_ff[cnt_ff][i] ? lane_acc + 12'(lane_val) : lane_acc - 12'(lane_val);
      end
   end

   // operand selection for the shared float unit
   always_comb begin
      fpu_req.start = 1'b0;
      fpu_req.op    = bwd_pkg::OP_MUL;
      fpu_req.a     = bwd_pkg::unpack_fp16(ascale_ff);
      fpu_req.b     = bwd_pkg::from_int(sum_ff);
      case (state_ff)
         S_P_GO: begin
            fpu_req.start = 1'b1;
         end
         S_B_GO: begin
            fpu_req.start = 1'b1;
            fpu_req.op    = bwd_pkg::OP_ADD;
            fpu_req.a     = bwd_pkg::unpack_fp32(block_ff);
            fpu_req.b     = bwd_pkg::unpack_fp32(tmp_ff);
         end
         S_Q_GO: begin
            fpu_req.start = 1'b1;
            fpu_req.a     = bwd_pkg::unpack_fp16(hws_ff);
            fpu_req.b     = bwd_pkg::unpack_fp32(block_ff);
         end
         S_T_GO: begin
            fpu_req.start = 1'b1;
            fpu_req.op    = bwd_pkg::OP_ADD;
            fpu_req.a     = bwd_pkg::unpack_fp32(total_ff);
            fpu_req.b     = bwd_pkg::unpack_fp32(tmp_ff);
         end
         default: fpu_req.start = 1'b0;
      endcase
   end

   bwd_fpu u_fpu (
      .clock (clock),
      .reset (reset),
      .req   (fpu_req),
      .rsp   (fpu_rsp)
   );

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      wb_in     = wb_ff;
      ascale_in = ascale_ff;
      hws_in    = hws_ff;
      last_in   = last_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      block_in  = block_ff;
      total_in  = total_ff;
      tmp_in    = tmp_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in  = odata_ff;
      ouser_in  = ouser_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               for (int g = 0; g < bwd_pkg::CHUNK_GROUPS; g++) begin
                  act_in[g] = req_tdata[64*g +: 64];
                  wb_in[g]  = req_tdata[256 + 8*g +: 8];
               end
               ascale_in = req_tdata[288 +: 16];
               if (pos_ff == PosW'(0)) begin
                  hws_in = req_tdata[304 +: 16];
               end
               last_in  = req_tlast;
               cnt_in   = CntW'(0);
               sum_in   = 14'sd0;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            sum_in = sum_ff + 14'(lane_acc);
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(bwd_pkg::CHUNK_GROUPS - 1)) begin
               state_in = S_P_GO;
            end
         end
         S_P_GO: state_in = S_P_WAIT;
         S_P_WAIT: begin
            if (fpu_rsp.done) begin
               tmp_in   = fpu_rsp.result;
               state_in = S_B_GO;
            end
         end
         S_B_GO: state_in = S_B_WAIT;
         S_B_WAIT: begin
            if (fpu_rsp.done) begin
               block_in = fpu_rsp.result;
               state_in = (full || last_ff) ? S_Q_GO : S_FIN;
            end
         end
         S_Q_GO: state_in = S_Q_WAIT;
         S_Q_WAIT: begin
            if (fpu_rsp.done) begin
               tmp_in   = fpu_rsp.result;
               state_in = S_T_GO;
            end
         end
         S_T_GO: state_in = S_T_WAIT;
         S_T_WAIT: begin
            if (fpu_rsp.done) begin
               total_in = fpu_rsp.result;
               block_in = 32'd0;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!last_ff) begin
               pos_in   = full ? PosW'(0) : pos_ff + PosW'(1);
               state_in = S_IDLE;
            end else if (out_free) begin
               // emit the dot product and clear the running state
               ovalid_in = 1'b1;
               if ((total_ff & bwd_pkg::FP32_EXP_MASK) == bwd_pkg::FP32_EXP_MASK &&
                   total_ff[22:0] != 23'd0) begin
                  odata_in = bwd_pkg::FP32_QNAN;
               end else begin
                  odata_in = total_ff;
               end
               ouser_in = !full;
               pos_in   = PosW'(0);
               hws_in   = 16'd0;
               block_in = 32'd0;
               total_in = 32'd0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pos_ff    <= PosW'(0);
         hws_ff    <= 16'd0;
         block_ff  <= 32'd0;
         total_ff  <= 32'd0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         hws_ff    <= hws_in;
         block_ff  <= block_in;
         total_ff  <= total_in;
         ovalid_ff <= ovalid_in;
         act_ff    <= act_in;
         wb_ff     <= wb_in;
         ascale_ff <= ascale_in;
         last_ff   <= last_in;
         cnt_ff    <= cnt_in;
         sum_ff    <= sum_in;
         tmp_ff    <= tmp_in;
         odata_ff  <= odata_in;
         ouser_ff  <= ouser_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ouser_ff;

endmodule

// ===== sv/bwd_fpu.sv =====
// shared multi-cycle fp32 multiply / add unit with round to nearest even
module bwd_fpu (
   input  logic                     clock,
   input  logic                     reset,
   input  bwd_pkg::bwd_fpu_req_type req,
   output bwd_pkg::bwd_fpu_rsp_type rsp
);

   typedef enum logic [1:0] {F_IDLE, F_NORM, F_DENORM, F_ROUND} fstate_type;

   fstate_type         state_ff, state_in;
   logic [47:0]        w_ff, w_in;
   logic signed [11:0] be_ff, be_in;
   logic               sgn_ff, sgn_in;
   logic               stk_ff, stk_in;
   logic               done_ff, done_in;
   logic [31:0]        res_ff, res_in;

   // start-cycle operand preparation
   logic               is_nan, is_inf, inf_sgn, zero_sgn, op_sgn;
   logic [47:0]        w_start;
   logic signed [11:0] be_start;
   bwd_pkg::bwd_opnd_type big, lit;
   logic [8:0]         shamt;
   logic [47:0]        b48, b_shift;
   logic               b_stk;

   always_comb begin
      big      = req.a;
      lit      = req.b;
      shamt    = 9'd0;
      b48      = 48'd0;
      b_shift  = 48'd0;
      b_stk    = 1'b0;
      is_nan   = 1'b0;
      is_inf   = 1'b0;
      inf_sgn  = 1'b0;
      zero_sgn = 1'b0;
      op_sgn   = 1'b0;
      w_start  = 48'd0;
      be_start = 12'sd0;
      if (req.op == bwd_pkg::OP_MUL) begin
         is_nan = (req.a.cls == bwd_pkg::CLS_NAN) || (req.b.cls == bwd_pkg::CLS_NAN) ||
                  (req.a.cls == bwd_pkg::CLS_INF && req.b.cls == bwd_pkg::CLS_ZERO) ||
                  (req.a.cls == bwd_pkg::CLS_ZERO && req.b.cls == bwd_pkg::CLS_INF);
         is_inf   = (req.a.cls == bwd_pkg::CLS_INF) || (req.b.cls == bwd_pkg::CLS_INF);
         inf_sgn  = req.a.sgn ^ req.b.sgn;
         zero_sgn = req.a.sgn ^ req.b.sgn;
         op_sgn   = req.a.sgn ^ req.b.sgn;
         w_start  = req.a.man * req.b.man;
         be_start = 12'(req.a.ex) + 12'(req.b.ex) - 12'sd126;
      end else begin
         is_nan = (req.a.cls == bwd_pkg::CLS_NAN) || (req.b.cls == bwd_pkg::CLS_NAN) ||
                  (req.a.cls == bwd_pkg::CLS_INF && req.b.cls == bwd_pkg::CLS_INF &&
                   req.a.sgn != req.b.sgn);
         is_inf   = (req.a.cls == bwd_pkg::CLS_INF) || (req.b.cls == bwd_pkg::CLS_INF);
         inf_sgn  = (req.a.cls == bwd_pkg::CLS_INF) ? req.a.sgn : req.b.sgn;
         zero_sgn = req.a.sgn & req.b.sgn;
         // larger magnitude first, smaller one aligned with a jammed sticky bit
         if ({req.a.ex, req.a.man} < {req.b.ex, req.b.man}) begin
            big = req.b;
            lit = req.a;
         end
         shamt = big.ex - lit.ex;
         b48   = {1'b0, lit.man, 23'd0};
         if (shamt >= 9'd48) begin
            b_shift = 48'd0;
            b_stk   = (lit.man != 24'd0);
         end else begin
            b_shift = b48 >> shamt;
            b_stk   = ((b_shift << shamt) != b48);
         end
         b_shift[0] = b_shift[0] | b_stk;
         op_sgn     = big.sgn;
         if (big.sgn ^ lit.sgn) begin
            w_start = {1'b0, big.man, 23'd0} - b_shift;
         end else begin
            w_start = {1'b0, big.man, 23'd0} + b_shift;
         end
         be_start = 12'(big.ex) + 12'sd1;
      end
   end

   // rounding of the normalized word
   logic [23:0]        mant, m2;
   logic               grd, sticky, rnd_up;
   logic [24:0]        rsum;
   logic signed [11:0] be2;

   always_comb begin
      mant   = w_ff[47:24];
      grd    = w_ff[23];
      sticky = (|w_ff[22:0]) | stk_ff;
      rnd_up = grd & (sticky | mant[0]);
      rsum   = 25'(mant) + 25'(rnd_up);
      if (rsum[24]) begin
         m2  = rsum[24:1];
         be2 = be_ff + 12'sd1;
      end else begin
         m2  = rsum[23:0];
         be2 = be_ff;
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      w_in     = w_ff;
      be_in    = be_ff;
      sgn_in   = sgn_ff;
      stk_in   = stk_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      case (state_ff)
         F_IDLE: begin
            if (req.start) begin
               if (is_nan) begin
                  res_in  = bwd_pkg::FP32_QNAN;
                  done_in = 1'b1;
               end else if (is_inf) begin
                  res_in  = {inf_sgn, 8'hff, 23'd0};
                  done_in = 1'b1;
               end else if (w_start == 48'd0) begin
                  res_in  = {zero_sgn, 31'd0};
                  done_in = 1'b1;
               end else begin
                  w_in     = w_start;
                  be_in    = be_start;
                  sgn_in   = op_sgn;
                  stk_in   = 1'b0;
                  state_in = F_NORM;
               end
            end
         end
         F_NORM: begin
            // left shift until the leading one sits at the top
            if (w_ff[47]) begin
               state_in = F_DENORM;
            end else if (w_ff[47:40] == 8'd0) begin
               w_in  = w_ff << 8;
               be_in = be_ff - 12'sd8;
            end else begin
               w_in  = w_ff << 1;
               be_in = be_ff - 12'sd1;
            end
         end
         F_DENORM: begin
            // right shift into the subnormal range, collecting sticky
            if (be_ff >= 12'sd1 || w_ff == 48'd0) begin
               state_in = F_ROUND;
            end else if (be_ff <= -12'sd7) begin
               stk_in = stk_ff | (|w_ff[7:0]);
               w_in   = w_ff >> 8;
               be_in  = be_ff + 12'sd8;
            end else begin
               stk_in = stk_ff | w_ff[0];
               w_in   = w_ff >> 1;
               be_in  = be_ff + 12'sd1;
            end
         end
         F_ROUND: begin
            if (be2 >= 12'sd255) begin
               res_in = {sgn_ff, 8'hff, 23'd0};
            end else begin
               res_in = {sgn_ff, (m2[23] ? be2[7:0] : 8'd0), m2[22:0]};
            end
            done_in  = 1'b1;
            state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   // state and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         w_ff     <= w_in;
         be_ff    <= be_in;
         sgn_ff   <= sgn_in;
         stk_ff   <= stk_in;
         res_ff   <= res_in;
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

// ===== sv/bwd_checker.sv =====
// port-level checker for the block dot unit and its bind
`include "binary_weight_int8_block_dot_defines.svh"

module bwd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [31:0]                    rsp_tdata,
   input logic                           rsp_tuser
);

   // a stalled result holds
   `BWD_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // one chunk at a time: busy right after a transfer
   `BWD_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready, "ready right after a chunk transfer")

   // a result never appears the cycle after a chunk is taken
   `BWD_ASSERT_NEXT(a_no_early_rsp, req_tvalid && req_tready, !$rose(rsp_tvalid), "result too soon after chunk")

   // any nan result is the canonical quiet nan
   `BWD_ASSERT_NOW(a_canon_nan, rsp_tvalid && rsp_tdata[30:23] == 8'hff && rsp_tdata[22:0] != 23'd0, rsp_tdata == bwd_pkg::FP32_QNAN, "non-canonical nan")

endmodule

bind binary_weight_int8_block_dot bwd_checker u_bwd_checker (.*);

// ===== sim/binary_weight_int8_block_dot_tb.sv =====
// self-checking testbench for the binary-weight int8 block dot product unit
`timescale 1ns / 100ps

module binary_weight_int8_block_dot_tb;

   localparam int BLOCK_CHUNKS = bwd_pkg::CHUNKS_PER_BLOCK_DEF;

   typedef struct {
      logic [31:0] dot;
      logic        partial;
   } dot_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [bwd_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           req_tlast = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [31:0]                    rsp_tdata;
   logic                           rsp_tuser;

   // predictor state: fp32 values kept as reals that are exactly representable
   int          pos_in_block;
   logic [15:0] latched_wscale;
   real         block_acc;
   real         total_acc;

   dot_result_type pending_dots[$];
   int             snd_idle = 0;
   int             rcv_idle = 0;
   int             mismatches = 0;
   int             chunks_sent = 0;
   int             frames_done = 0;
   int             partial_frames = 0;
   int             results_seen = 0;

   binary_weight_int8_block_dot dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // fp16 widened exactly to a real
   function automatic real half_value(logic [15:0] h);
      logic [63:0] d;
      real         v;
      if (h[14:10] == 5'h1f) begin
         d = {h[15], 11'h7ff, h[9:0], 42'd0};
         return $bitstoreal(d);
      end
      if (h[14:10] == 5'h00) begin
         v = real'(h[9:0]) / 16777216.0;
         if (h[15]) v = -v;
         if (h[9:0] == 0) return $bitstoreal({h[15], 63'd0});
         return v;
      end
      d = {h[15], 11'(h[14:10]) + 11'd1008, h[9:0], 42'd0};
      return $bitstoreal(d);
   endfunction

   function automatic real single_value(logic [31:0] b);
      real v;
      if (b[30:23] == 8'hff) return $bitstoreal({b[31], 11'h7ff, b[22:0], 29'd0});
      if (b[30:23] == 8'h00) begin
         if (b[22:0] == 0) return $bitstoreal({b[31], 63'd0});
         v = real'(b[22:0]) * (2.0 ** -149);
         return b[31] ? -v : v;
      end
      return $bitstoreal({b[31], 11'(b[30:23]) + 11'd896, b[22:0], 29'd0});
   endfunction

   // round a real to fp32, nearest even, subnormals kept
   function automatic logic [31:0] round_single(real r);
      logic [63:0] d, sig, q, rem, half;
      int          ue, shift, biased;
      d = $realtobits(r);
      if (d[62:52] == 11'h7ff)
         return (d[51:0] != 0) ? bwd_pkg::FP32_QNAN : {d[63], 8'hff, 23'd0};
      if (d[62:52] == 11'h000) return {d[63], 31'd0};
      ue = int'(d[62:52]) - 1023;
      sig = {11'd1, d[51:0]};
      shift = (ue >= -126) ? 29 : 29 + (-126 - ue);
      if (shift > 54) return {d[63], 31'd0};
      q = sig >> shift;
      half = 64'd1 << (shift - 1);
      rem = sig & ((64'd1 << shift) - 64'd1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      if (ue < -126) return {d[63], 31'(q)};
      biased = ue + 127;
      if (q == (64'd1 << 24)) begin
         q = q >> 1;
         biased++;
      end
      if (biased >= 255) return {d[63], 8'hff, 23'd0};
      return {d[63], 8'(biased), q[22:0]};
   endfunction

   function automatic real fp32_op(real x);
      return single_value(round_single(x));
   endfunction

   function automatic int signed_chunk_sum(logic [bwd_pkg::REQ_DATA_W-1:0] data);
      int          s;
      logic [7:0]  a;
      s = 0;
      for (int j = 0; j < 32; j++) begin
         a = data[8*j +: 8];
         if (data[256 + j]) s += int'($signed(a));
         else s -= int'($signed(a));
      end
      return s;
   endfunction

   function automatic void clear_dot_state();
      pos_in_block = 0;
      latched_wscale = '0;
      block_acc = 0.0;
      total_acc = 0.0;
   endfunction

   // fold the current block into the running total
   function automatic void fold_block();
      total_acc = fp32_op(total_acc + fp32_op(half_value(latched_wscale) * block_acc));
      block_acc = 0.0;
   endfunction

   // advance the predictor by one accepted chunk
   function automatic void predict_chunk(logic [bwd_pkg::REQ_DATA_W-1:0] data, logic last);
      dot_result_type res;
      logic           partial;
      partial = 1'b0;
      if (pos_in_block == 0) latched_wscale = data[319:304];
      block_acc = fp32_op(block_acc +
         fp32_op(half_value(data[303:288]) * real'(signed_chunk_sum(data))));
      pos_in_block++;
      if (pos_in_block >= BLOCK_CHUNKS) begin
         fold_block();
         pos_in_block = 0;
      end else if (last) begin
         fold_block();
         partial = 1'b1;
      end
      if (last) begin
         res.dot = round_single(total_acc);
         if (res.dot[30:23] == 8'hff && res.dot[22:0] != 0) res.dot = bwd_pkg::FP32_QNAN;
         res.partial = partial;
         pending_dots.push_back(res);
         frames_done++;
         if (partial) partial_frames++;
         clear_dot_state();
      end
   endfunction

   // one chunk transfer with random gaps before it
   task automatic send_chunk(logic [bwd_pkg::REQ_DATA_W-1:0] data, logic last);
      while ($urandom_range(99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      predict_chunk(data, last);
      chunks_sent++;
   endtask

   task automatic go_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      go_quiet();
      while (pending_dots.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_act();
      case ($urandom_range(9))
         0: return 8'h80;
         1: return 8'h7f;
         2: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   // mostly moderate fp16 scales, now and then the special encodings
   function automatic logic [15:0] rand_half();
      int k;
      k = $urandom_range(59);
      if (k < 44) return {1'($urandom), 5'($urandom_range(18, 8)), 10'($urandom)};
      if (k < 47) return {1'($urandom), 15'd0};
      if (k < 52) return {1'($urandom), 5'd0, 10'($urandom)};
      if (k < 55) return {1'($urandom), 5'($urandom_range(30, 19)), 10'($urandom)};
      if (k < 57) return 16'($urandom);
      if (k < 58) return {1'($urandom), 5'h1f, 10'd0};
      return {1'($urandom), 5'h1f, 10'($urandom_range(1023, 1))};
   endfunction

   function automatic logic [bwd_pkg::REQ_DATA_W-1:0] rand_chunk();
      logic [bwd_pkg::REQ_DATA_W-1:0] d;
      int                             k;
      for (int j = 0; j < 32; j++) d[8*j +: 8] = rand_act();
      k = $urandom_range(9);
      d[287:256] = (k == 0) ? 32'hffff_ffff : (k == 1) ? 32'h0 : 32'($urandom);
      d[303:288] = rand_half();
      d[319:304] = rand_half();
      return d;
   endfunction

   function automatic logic [bwd_pkg::REQ_DATA_W-1:0] make_chunk(logic [7:0] act,
      logic [31:0] w, logic [15:0] as, logic [15:0] ws);
      logic [bwd_pkg::REQ_DATA_W-1:0] d;
      for (int j = 0; j < 32; j++) d[8*j +: 8] = act;
      d[287:256] = w;
      d[303:288] = as;
      d[319:304] = ws;
      return d;
   endfunction

   // extreme activations and every special fp16 encoding, mostly single-chunk frames
   task automatic test_field_extremes();
      send_chunk(make_chunk(8'h80, 32'hffff_ffff, 16'h3c00, 16'h3c00), 1'b1);
      send_chunk(make_chunk(8'h80, 32'h0, 16'h3c00, 16'h3c00), 1'b1);
      send_chunk(make_chunk(8'h7f, 32'hffff_ffff, 16'h7bff, 16'h7bff), 1'b1);
      send_chunk(make_chunk(8'h7f, 32'h5555_aaaa, 16'h0001, 16'h0001), 1'b1);
      send_chunk(make_chunk(8'h00, 32'hffff_ffff, 16'h8000, 16'h3c00), 1'b1);
      send_chunk(make_chunk(8'h01, 32'h0, 16'h8000, 16'hbc00), 1'b1);
      send_chunk(make_chunk(8'h7f, 32'hffff_ffff, 16'h7c00, 16'h3c00), 1'b1);
      send_chunk(make_chunk(8'h00, 32'hffff_ffff, 16'h7c00, 16'h3c00), 1'b1);
      send_chunk(make_chunk(8'h80, 32'hffff_ffff, 16'hfc00, 16'h0000), 1'b1);
      send_chunk(make_chunk(8'h11, 32'h0f0f_f0f0, 16'h7e01, 16'h3c00), 1'b1);
      send_chunk(make_chunk(8'h11, 32'hffff_ffff, 16'h3c00, 16'hfe00), 1'b1);
      send_chunk(make_chunk(8'h7f, 32'hffff_ffff, 16'h03ff, 16'h8001), 1'b1);
      // two-chunk frame: the weight scale is latched from the first chunk only
      send_chunk(make_chunk(8'h7f, 32'hffff_ffff, 16'h7bff, 16'h7bff), 1'b0);
      send_chunk(make_chunk(8'h7f, 32'hffff_ffff, 16'h7bff, 16'h0000), 1'b1);
      wait_drained();
   endtask

   // last on each position of a block, and frames spanning several blocks
   task automatic test_block_boundaries();
      for (int len = 1; len <= 2 * BLOCK_CHUNKS + 1; len++)
         for (int c = 0; c < len; c++) send_chunk(rand_chunk(), c == len - 1);
      // +inf and -inf in separate blocks cancel to nan
      send_chunk(make_chunk(8'h01, 32'hffff_ffff, 16'h3c00, 16'h7c00), 1'b0);
      for (int c = 0; c < BLOCK_CHUNKS - 1; c++)
         send_chunk(make_chunk(8'h01, 32'hffff_ffff, 16'h3c00, 16'h3c00), 1'b0);
      send_chunk(make_chunk(8'h01, 32'hffff_ffff, 16'h3c00, 16'hfc00), 1'b1);
      wait_drained();
   endtask

   // random frames of random length
   task automatic test_random_frames(int n_chunks, int s_idle, int r_idle);
      int left, len;
      snd_idle = s_idle;
      rcv_idle = r_idle;
      left = n_chunks;
      while (left > 0) begin
         len = ($urandom_range(3) == 0) ? $urandom_range(14, 1) : $urandom_range(6, 1);
         if (len > left) len = left;
         for (int c = 0; c < len; c++) send_chunk(rand_chunk(), c == len - 1);
         left -= len;
         // hold off now and then until every result is back
         if ($urandom_range(19) == 0) wait_drained();
      end
      wait_drained();
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rcv_idle);
   end

   // compare each result transfer against the oldest expectation
   always @(posedge clock) begin
      dot_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_dots.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result dot=%h partial=%b",
                                           rsp_tdata, rsp_tuser);
         end else begin
            exp_r = pending_dots.pop_front();
            if (rsp_tdata !== exp_r.dot || rsp_tuser !== exp_r.partial) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: dot exp=%h got=%h  partial exp=%b got=%b",
                           exp_r.dot, rsp_tdata, exp_r.partial, rsp_tuser);
            end
         end
      end
   end

   // run limit
   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      clear_dot_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_block_boundaries();
      test_random_frames(640, 12, 52);
      test_random_frames(640, 52, 12);
      test_random_frames(640, 0, 0);
      repeat (200) @(posedge clock);
      $display("covered %0d chunks in %0d frames (%0d closing mid-block), %0d results",
               chunks_sent, frames_done, partial_frames, results_seen);
      $display("left over expectations: %0d, mismatches: %0d",
               pending_dots.size(), mismatches);
      if (mismatches == 0 && pending_dots.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
